FILE: hw/rtl/mc_pkg.sv
// Shared types, constants and code table of the Morse codec.
package mc_pkg;

    localparam int MAX_SYMBOLS  = 5;
    localparam int NUM_GLYPHS   = 36;
    localparam int CODE_W       = 5;
    localparam int LEN_W        = 3;
    localparam int CODE_MAX_LEN = 5;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    // Each entry holds the symbol count and the symbols, oldest in the
    // highest used bit, dash = 1. Order: A..Z, then 1..9, then 0.
    localparam logic [LEN_W+CODE_W-1:0] CODE_TABLE [NUM_GLYPHS] = '{
        {3'd2, 5'b00001}, {3'd4, 5'b01000}, {3'd4, 5'b01010}, {3'd3, 5'b00100},
        {3'd1, 5'b00000}, {3'd4, 5'b00010}, {3'd3, 5'b00110}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b00111}, {3'd3, 5'b00101}, {3'd4, 5'b00100},
        {3'd2, 5'b00011}, {3'd2, 5'b00010}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
        {3'd4, 5'b01101}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
        {3'd3, 5'b00001}, {3'd4, 5'b00001}, {3'd3, 5'b00011}, {3'd4, 5'b01001},
        {3'd4, 5'b01011}, {3'd4, 5'b01100},
        {3'd5, 5'b01111}, {3'd5, 5'b00111}, {3'd5, 5'b00011}, {3'd5, 5'b00001},
        {3'd5, 5'b00000}, {3'd5, 5'b10000}, {3'd5, 5'b11000}, {3'd5, 5'b11100},
        {3'd5, 5'b11110}, {3'd5, 5'b11111}
    };

    // Work handed from the front end to the back end.
    typedef struct packed {
        logic              is_enc;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
        logic [7:0]        glyph;
    } job_t;

    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } enc_lookup_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] glyph;
    } dec_lookup_t;

    function automatic logic [7:0] glyph_of(input logic [5:0] idx);
        logic [7:0] g;
        if (idx < 6'd26) begin
            g = CHAR_UP_A + {2'b00, idx};
        end else if (idx == 6'd35) begin
            g = CHAR_ZERO;
        end else begin
            g = CHAR_ONE + {2'b00, idx} - 8'd26;
        end
        return g;
    endfunction

    function automatic enc_lookup_t char_to_code(input logic [7:0] c);
        logic [7:0]  u;
        logic [7:0]  ofs;
        enc_lookup_t r;
        u   = (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? (c - CASE_FOLD) : c;
        r   = '0;
        ofs = '0;
        if (u >= CHAR_UP_A && u <= CHAR_UP_Z) begin
            r.hit = 1'b1;
            ofs   = u - CHAR_UP_A;
        end else if (u >= CHAR_ONE && u <= CHAR_NINE) begin
            r.hit = 1'b1;
            ofs   = u - CHAR_ONE + 8'd26;
        end else if (u == CHAR_ZERO) begin
            r.hit = 1'b1;
            ofs   = 8'd35;
        end
        if (r.hit) begin
            {r.len, r.bits} = CODE_TABLE[ofs[5:0]];
        end
        return r;
    endfunction

    function automatic dec_lookup_t match_code(input logic [LEN_W-1:0] len,
                                               input logic [CODE_W-1:0] bits);
        dec_lookup_t r;
        r = '0;
        for (int k = 0; k < NUM_GLYPHS; k++) begin
            if (CODE_TABLE[k] == {len, bits}) begin
                r.hit   = 1'b1;
                r.glyph = glyph_of(6'(k));
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/morse_codec.sv
// Top level of the Morse codec: front end, job queue and back end.
//
// The codec encodes ASCII letters (either case) and digits into Morse dots
// and dashes, or decodes runs of dots and dashes back to uppercase letters
// and digits, as selected by the mode register (0 encodes, 1 decodes).
// Writing the mode register also clears the decoder's code buffer. In
// encode mode each known character yields its symbols, one per output
// request, and then a space with tlast set; unknown characters yield
// nothing. In decode mode a space, or any request with s_tlast set, ends
// the current run, and a valid run yields one character with tlast set.
// The front end takes one input request per cycle while the job queue has
// room. The back end sends one output request per cycle while the output
// is not held by back-pressure, so an encoded character takes its symbol
// count plus one output requests and a decoded character takes one; the
// sustained encode rate is therefore set by the back end's single output register.
module morse_codec #(
    parameter int MAX_SYMBOLS = mc_pkg::MAX_SYMBOLS
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Mode register write: bit 0 is the mode.
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_wr_data,
    // Input requests.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // end_of_text
    // Output requests.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast    // last
);

    logic         q_full;
    logic         q_push;
    mc_pkg::job_t q_push_job;
    logic         q_pop;
    logic         q_not_empty;
    mc_pkg::job_t q_head;

    // The front end classifies each request and turns it into at most one job.
    mc_front #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data[0]),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_push_job)
    );

    // The queue lets input keep flowing while long encodings drain.
    mc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head_job (q_head)
    );

    // The back end expands each job into output requests.
    mc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: hw/rtl/mc_front.sv
// Front end: takes requests, looks up or collects codes, and queues jobs.
module mc_front #(
    parameter int MAX_SYMBOLS = mc_pkg::MAX_SYMBOLS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         q_full,
    output logic         q_push,
    output mc_pkg::job_t q_job
);

    localparam int LW = $clog2(MAX_SYMBOLS + 1);

    logic                   mode_reg, mode_next;
    logic [MAX_SYMBOLS-1:0] bits_reg, bits_next;
    logic [LW-1:0]          len_reg, len_next;
    logic                   inv_reg, inv_next;

    logic                accept;
    logic                is_dot, is_dash, is_space;
    mc_pkg::enc_lookup_t enc;
    mc_pkg::dec_lookup_t dec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_dot   = (s_tdata == mc_pkg::CHAR_DOT);
    assign is_dash  = (s_tdata == mc_pkg::CHAR_DASH);
    assign is_space = (s_tdata == mc_pkg::CHAR_SPACE);
    assign enc      = mc_pkg::char_to_code(s_tdata);

    always_comb begin
        mode_next = mode_reg;
        bits_next = bits_reg;
        len_next  = len_reg;
        inv_next  = inv_reg;
        q_push    = 1'b0;
        q_job     = '0;
        dec       = '0;
        if (cfg_wr_en) begin
            mode_next = cfg_wr_data;
            bits_next = '0;
            len_next  = '0;
            inv_next  = 1'b0;
        end else if (accept) begin
            if (mode_reg == mc_pkg::MODE_ENCODE) begin
                q_push       = enc.hit;
                q_job.is_enc = 1'b1;
                q_job.len    = enc.len;
                q_job.bits   = enc.bits;
            end else begin
                if (is_dot || is_dash) begin
                    if (len_reg < LW'(MAX_SYMBOLS)) begin
                        bits_next = {bits_reg[MAX_SYMBOLS-2:0], is_dash};
                        len_next  = len_reg + 1'b1;
                    end else begin
                        inv_next = 1'b1;
                    end
                end else if (!is_space) begin
                    inv_next = 1'b1;
                end
                if (is_space || s_tlast) begin
                    // Only runs of table length can match; shorter runs keep
                    // zeros in the upper buffer bits.
                    dec = mc_pkg::match_code(len_next[mc_pkg::LEN_W-1:0],
                                             bits_next[mc_pkg::CODE_W-1:0]);
                    q_push = (len_next != '0) && !inv_next &&
                             (len_next <= LW'(mc_pkg::CODE_MAX_LEN)) && dec.hit;
                    q_job.glyph = dec.glyph;
                    bits_next   = '0;
                    len_next    = '0;
                    inv_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mc_pkg::MODE_ENCODE;
            bits_reg <= '0;
            len_reg  <= '0;
            inv_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            bits_reg <= bits_next;
            len_reg  <= len_next;
            inv_reg  <= inv_next;
        end
    end

endmodule

FILE: hw/rtl/mc_queue.sv
// Short job queue between the front end and the back end.
module mc_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  mc_pkg::job_t push_job,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output mc_pkg::job_t head_job
);

    localparam int AW = $clog2(mc_pkg::QUEUE_DEPTH);

    mc_pkg::job_t    mem [mc_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == (AW+1)'(mc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/mc_back.sv
// Back end: expands queued jobs into output characters one per cycle while the output is not held by back-pressure.
module mc_back (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_not_empty,
    input  mc_pkg::job_t q_head,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);

    mc_pkg::job_t            job_reg, job_next;
    logic                    busy_reg, busy_next;
    logic [mc_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic                    vld_reg, vld_next;
    logic [7:0]              data_reg, data_next;
    logic                    last_reg, last_next;

    logic                     out_ok, emit, final_item;
    logic [mc_pkg::LEN_W-1:0] pos;
    logic [mc_pkg::CODE_W-1:0] shifted;
    logic [7:0]               item_char;

    assign out_ok     = !vld_reg || m_tready;
    assign emit       = busy_reg && out_ok;
    assign final_item = !job_reg.is_enc || (idx_reg == job_reg.len);
    assign q_pop      = q_not_empty && (!busy_reg || (emit && final_item));
    assign pos        = job_reg.len - 1'b1 - idx_reg;
    assign shifted    = job_reg.bits >> pos;

    always_comb begin
        if (!job_reg.is_enc) begin
            item_char = job_reg.glyph;
        end else if (final_item) begin
            item_char = mc_pkg::CHAR_SPACE;
        end else begin
            item_char = shifted[0] ? mc_pkg::CHAR_DASH : mc_pkg::CHAR_DOT;
        end
    end

    always_comb begin
        job_next  = job_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        vld_next  = vld_reg;
        data_next = data_reg;
        last_next = last_reg;
        if (out_ok) begin
            vld_next  = emit;
            data_next = item_char;
            last_next = final_item;
        end
        if (q_pop) begin
            job_next  = q_head;
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (emit && final_item) begin
            busy_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        data_reg <= data_next;
        last_reg <= last_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
